// ===== rtl/core/qosc_pkg.sv =====
package qosc_pkg;

  localparam int CoefW          = 32;
  localparam int OutW           = 32;
  localparam int CfgDataW       = 32;
  localparam int CfgIdxW        = 2;
  localparam int SampleWidthDef = 32;
  localparam int MulBW          = 24;
  localparam int ProdW          = CoefW + MulBW;
  localparam int LoW            = ProdW + 1 - MulBW;
  localparam int MagW           = ProdW + 1;
  localparam int K1Frac         = 24;
  localparam int K2Frac         = 30;
  localparam int K1Shift        = K1Frac - MulBW;
  localparam int K2Shift        = K2Frac - MulBW;
  localparam logic [ProdW-1:0] K1Rnd = ProdW'(1) << (K1Frac - 1);
  localparam logic [ProdW-1:0] K2Rnd = ProdW'(1) << (K2Frac - 1);
  localparam int StepW          = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_K1      = 2'd0,
    CFG_COEF_K2      = 2'd1,
    CFG_RESET_ENABLE = 2'd2,
    CFG_SYNC_ENABLE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_FIN,
    OP_ACC,
    OP_LOAD,
    OP_EMIT
  } op_e;

  typedef enum logic {
    COEF_K1,
    COEF_K2
  } coef_e;

  typedef enum logic [1:0] {
    OPND_U,
    OPND_V,
    OPND_W
  } opnd_e;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_JUMP,
    BR_INPUT,
    BR_OUTPUT
  } br_e;

  typedef struct packed {
    op_e              op;
    coef_e            coef;
    opnd_e            mul_src;
    opnd_e            add_src;
    opnd_e            dst;
    logic             sub;
    br_e              br;
    logic [StepW-1:0] target;
  } uword_t;

  localparam logic [StepW-1:0] StepWait = StepW'(0);
  localparam logic [StepW-1:0] StepLoad = StepW'(13);
  localparam logic [StepW-1:0] StepEmit = StepW'(14);

  function automatic uword_t uw_mul(input op_e op, input coef_e coef, input opnd_e src);
    uword_t w;
    w         = '0;
    w.op      = op;
    w.coef    = coef;
    w.mul_src = src;
    w.add_src = OPND_U;
    w.dst     = OPND_U;
    w.br      = BR_NEXT;
    return w;
  endfunction

  function automatic uword_t uw_acc(input coef_e coef, input opnd_e add_src,
                                    input opnd_e dst, input logic sub);
    uword_t w;
    w         = '0;
    w.op      = OP_ACC;
    w.coef    = coef;
    w.mul_src = OPND_U;
    w.add_src = add_src;
    w.dst     = dst;
    w.sub     = sub;
    w.br      = BR_NEXT;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [StepW-1:0] step);
    uword_t w;
    w         = '0;
    w.op      = OP_NOP;
    w.coef    = COEF_K1;
    w.mul_src = OPND_U;
    w.add_src = OPND_U;
    w.dst     = OPND_U;
    w.br      = BR_JUMP;
    w.target  = StepWait;
    case (step)
      StepW'(0): begin
        w.br     = BR_INPUT;
        w.target = StepLoad;
      end
      StepW'(1):  w = uw_mul(OP_MUL_LO, COEF_K1, OPND_V);
      StepW'(2):  w = uw_mul(OP_MUL_HI, COEF_K1, OPND_V);
      StepW'(3):  w = uw_mul(OP_FIN, COEF_K1, OPND_V);
      StepW'(4):  w = uw_acc(COEF_K1, OPND_U, OPND_W, 1'b1);
      StepW'(5):  w = uw_mul(OP_MUL_LO, COEF_K2, OPND_W);
      StepW'(6):  w = uw_mul(OP_MUL_HI, COEF_K2, OPND_W);
      StepW'(7):  w = uw_mul(OP_FIN, COEF_K2, OPND_W);
      StepW'(8):  w = uw_acc(COEF_K2, OPND_V, OPND_V, 1'b0);
      StepW'(9):  w = uw_mul(OP_MUL_LO, COEF_K1, OPND_V);
      StepW'(10): w = uw_mul(OP_MUL_HI, COEF_K1, OPND_V);
      StepW'(11): w = uw_mul(OP_FIN, COEF_K1, OPND_V);
      StepW'(12): begin
        w        = uw_acc(COEF_K1, OPND_W, OPND_U, 1'b1);
        w.br     = BR_JUMP;
        w.target = StepEmit;
      end
      StepW'(13): begin
        w.op = OP_LOAD;
        w.br = BR_NEXT;
      end
      StepW'(14): begin
        w.op     = OP_EMIT;
        w.br     = BR_OUTPUT;
        w.target = StepWait;
      end
      default: begin
        w.br     = BR_JUMP;
        w.target = StepWait;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/qosc_in_if.sv =====
interface qosc_in_if;
  logic valid;
  logic ready;
  logic reset_level;

  modport source (output valid, output reset_level, input ready);
  modport sink (input valid, input reset_level, output ready);
endinterface

// ===== rtl/core/qosc_out_if.sv =====
interface qosc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qosc_pkg::OutW-1:0]    cos_out;
  logic signed [qosc_pkg::OutW-1:0]    sin_out;
  logic                                cos_sync;
  logic                                sin_sync;

  modport source (output valid, output cos_out, output sin_out, output cos_sync,
                  output sin_sync, input ready);
  modport sink (input valid, input cos_out, input sin_out, input cos_sync,
                input sin_sync, output ready);
endinterface

// ===== rtl/core/quadrature_oscillator_sync_top.sv =====
// Channel   Modport  Payload                                   Direction
// in_i      sink     reset_level                               into the block
// out_o     source   cos_out, sin_out, cos_sync, sin_sync      out of the block
// cfg       -        cfg_we_i, cfg_idx_i, cfg_data_i           into the block
//
// A free-running sample runs from acceptance to the next acceptance through
// three products on one 32x24 multiplier, each as two partial products, a
// rounding step and a saturating add. A phase-reset sample loads, then emits.
// Reset puts the state at cosine one, sine zero, and clears all coefficients.
// A stalled output register holds the result while the next sample is accepted;
// the sequencer waits at its last step only when a second result is ready.
module quadrature_oscillator_sync_top #(
  parameter int SampleWidth = qosc_pkg::SampleWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  qosc_in_if.sink                            in_i,
  qosc_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [qosc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [qosc_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int WideW = SampleWidth + qosc_pkg::OutW;

  logic signed [qosc_pkg::CoefW-1:0]   k1_q, k2_q;
  logic                                rst_en_q, sync_en_q;
  logic [qosc_pkg::StepW-1:0]          step_q, step_d;
  logic                                prev_lvl_q, cwp_q, swp_q, out_valid_q;
  logic signed [qosc_pkg::OutW-1:0]    cos_out_q, sin_out_q;
  logic                                cos_sync_q, sin_sync_q;

  qosc_pkg::uword_t                    uw;
  logic                                in_acc, rst_cond, emit_ok, emit;
  logic signed [SampleWidth-1:0]       u, v;
  logic signed [WideW-1:0]             u_wide, v_wide;
  logic signed [qosc_pkg::OutW-1:0]    cos_val, sin_val;
  logic                                cpos, spos;

  qosc_dp #(
    .SampleWidth(SampleWidth)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .uw_i  (uw),
    .k1_i  (k1_q),
    .k2_i  (k2_q),
    .cos_o (u),
    .sin_o (v)
  );

  assign uw       = qosc_pkg::ucode(step_q);
  assign in_i.ready = (uw.br == qosc_pkg::BR_INPUT);
  assign in_acc   = in_i.valid && in_i.ready;
  assign rst_cond = rst_en_q && (in_i.reset_level != prev_lvl_q);
  assign emit_ok  = !out_valid_q || out_o.ready;
  assign emit     = (uw.op == qosc_pkg::OP_EMIT) && emit_ok;

  always_comb begin
    case (uw.br)
      qosc_pkg::BR_NEXT:   step_d = step_q + qosc_pkg::StepW'(1);
      qosc_pkg::BR_JUMP:   step_d = uw.target;
      qosc_pkg::BR_INPUT: begin
        if (in_acc) begin
          step_d = rst_cond ? uw.target : step_q + qosc_pkg::StepW'(1);
        end else begin
          step_d = step_q;
        end
      end
      qosc_pkg::BR_OUTPUT: step_d = emit_ok ? uw.target : step_q;
      default:             step_d = qosc_pkg::StepWait;
    endcase
  end

  always_comb begin
    u_wide  = $signed({u, qosc_pkg::OutW'(0)}) >>> SampleWidth;
    v_wide  = $signed({v, qosc_pkg::OutW'(0)}) >>> SampleWidth;
    cos_val = u_wide[qosc_pkg::OutW-1:0];
    sin_val = v_wide[qosc_pkg::OutW-1:0];
    cpos    = !u[SampleWidth-1] && (|u);
    spos    = !v[SampleWidth-1] && (|v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q        <= '0;
      k2_q        <= '0;
      rst_en_q    <= 1'b0;
      sync_en_q   <= 1'b0;
      step_q      <= qosc_pkg::StepWait;
      prev_lvl_q  <= 1'b0;
      cwp_q       <= 1'b0;
      swp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (qosc_pkg::cfg_idx_e'(cfg_idx_i))
          qosc_pkg::CFG_COEF_K1:      k1_q      <= $signed(cfg_data_i[qosc_pkg::CoefW-1:0]);
          qosc_pkg::CFG_COEF_K2:      k2_q      <= $signed(cfg_data_i[qosc_pkg::CoefW-1:0]);
          qosc_pkg::CFG_RESET_ENABLE: rst_en_q  <= cfg_data_i[0];
          qosc_pkg::CFG_SYNC_ENABLE:  sync_en_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      step_q <= step_d;
      if (in_acc) begin
        prev_lvl_q <= in_i.reset_level;
      end
      if (emit) begin
        cwp_q       <= cpos;
        swp_q       <= spos;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cos_out_q  <= cos_val;
      sin_out_q  <= sin_val;
      cos_sync_q <= sync_en_q && cpos && !cwp_q;
      sin_sync_q <= sync_en_q && spos && !swp_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.cos_out  = cos_out_q;
  assign out_o.sin_out  = sin_out_q;
  assign out_o.cos_sync = cos_sync_q;
  assign out_o.sin_sync = sin_sync_q;

endmodule

// ===== rtl/core/qosc_dp.sv =====
module qosc_dp #(
  parameter int SampleWidth = qosc_pkg::SampleWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  qosc_pkg::uword_t                     uw_i,
  input  logic signed [qosc_pkg::CoefW-1:0]    k1_i,
  input  logic signed [qosc_pkg::CoefW-1:0]    k2_i,
  output logic signed [SampleWidth-1:0]        cos_o,
  output logic signed [SampleWidth-1:0]        sin_o
);

  localparam int ExtW = 2 * qosc_pkg::MulBW;
  localparam int RW   = qosc_pkg::MagW + 1;
  localparam logic signed [SampleWidth-1:0] One  = SampleWidth'(1) << (SampleWidth - 2);
  localparam logic signed [SampleWidth-1:0] SMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic signed [SampleWidth-1:0] SMin = {1'b1, {(SampleWidth-1){1'b0}}};

  logic signed [SampleWidth-1:0]       u_q, v_q, w_q;
  logic [qosc_pkg::ProdW-1:0]          prod_q;
  logic [qosc_pkg::LoW-1:0]            lo_q;
  logic [qosc_pkg::MagW-1:0]           mag_q;
  logic                                neg_q;

  logic signed [qosc_pkg::CoefW-1:0]   coef;
  logic signed [SampleWidth-1:0]       opnd_b;
  logic signed [SampleWidth-1:0]       addend;
  logic [qosc_pkg::CoefW-1:0]          coef_mag;
  logic [SampleWidth-1:0]              b_mag;
  logic [ExtW-1:0]                     b_ext;
  logic [qosc_pkg::MulBW-1:0]          mul_b;
  logic [qosc_pkg::ProdW-1:0]          prod;
  logic [qosc_pkg::ProdW-1:0]          rnd;
  logic [qosc_pkg::MagW-1:0]           lo_sum;
  logic [qosc_pkg::MagW-1:0]           fin_sum;
  logic [qosc_pkg::MagW-1:0]           mag_d;
  logic signed [RW-1:0]                ax, mx, res;
  logic                                ovf;
  logic signed [SampleWidth-1:0]       acc_res;

  always_comb begin
    coef = (uw_i.coef == qosc_pkg::COEF_K1) ? k1_i : k2_i;
    case (uw_i.mul_src)
      qosc_pkg::OPND_U: opnd_b = u_q;
      qosc_pkg::OPND_V: opnd_b = v_q;
      qosc_pkg::OPND_W: opnd_b = w_q;
      default:          opnd_b = u_q;
    endcase
    case (uw_i.add_src)
      qosc_pkg::OPND_U: addend = u_q;
      qosc_pkg::OPND_V: addend = v_q;
      qosc_pkg::OPND_W: addend = w_q;
      default:          addend = u_q;
    endcase
    coef_mag = coef[qosc_pkg::CoefW-1] ? qosc_pkg::CoefW'(-coef) : qosc_pkg::CoefW'(coef);
    b_mag    = opnd_b[SampleWidth-1] ? SampleWidth'(-opnd_b) : SampleWidth'(opnd_b);
    b_ext    = ExtW'(b_mag);
    mul_b    = (uw_i.op == qosc_pkg::OP_MUL_HI) ? b_ext[ExtW-1:qosc_pkg::MulBW]
                                                : b_ext[qosc_pkg::MulBW-1:0];
    prod     = qosc_pkg::ProdW'(coef_mag) * qosc_pkg::ProdW'(mul_b);
    rnd      = (uw_i.coef == qosc_pkg::COEF_K1) ? qosc_pkg::K1Rnd : qosc_pkg::K2Rnd;
    lo_sum   = qosc_pkg::MagW'(prod_q) + qosc_pkg::MagW'(rnd);
    fin_sum  = qosc_pkg::MagW'(prod_q) + qosc_pkg::MagW'(lo_q);
    mag_d    = (uw_i.coef == qosc_pkg::COEF_K1) ? (fin_sum >> qosc_pkg::K1Shift)
                                                : (fin_sum >> qosc_pkg::K2Shift);
    ax       = RW'(addend);
    mx       = $signed({1'b0, mag_q});
    res      = (uw_i.sub ^ neg_q) ? (ax - mx) : (ax + mx);
    ovf      = !((&res[RW-1:SampleWidth-1]) || !(|res[RW-1:SampleWidth-1]));
    if (ovf) begin
      acc_res = res[RW-1] ? SMin : SMax;
    end else begin
      acc_res = res[SampleWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q <= One;
      v_q <= '0;
    end else begin
      if (uw_i.op == qosc_pkg::OP_LOAD) begin
        u_q <= One;
        v_q <= '0;
      end else if (uw_i.op == qosc_pkg::OP_ACC) begin
        if (uw_i.dst == qosc_pkg::OPND_U) u_q <= acc_res;
        if (uw_i.dst == qosc_pkg::OPND_V) v_q <= acc_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (uw_i.op)
      qosc_pkg::OP_MUL_LO: begin
        prod_q <= prod;
        neg_q  <= coef[qosc_pkg::CoefW-1] ^ opnd_b[SampleWidth-1];
      end
      qosc_pkg::OP_MUL_HI: begin
        prod_q <= prod;
        lo_q   <= lo_sum[qosc_pkg::MagW-1:qosc_pkg::MulBW];
      end
      qosc_pkg::OP_FIN: begin
        mag_q <= mag_d;
      end
      qosc_pkg::OP_ACC: begin
        if (uw_i.dst == qosc_pkg::OPND_W) w_q <= acc_res;
      end
      default: begin
      end
    endcase
  end

  assign cos_o = u_q;
  assign sin_o = v_q;

endmodule
